FILE: hdl/skf_pkg.sv
// skf_pkg: shared types, constants and the microcode table of the scalar kalman filter
// control word layout, operand and operation codes, configuration register map
// no dependencies; every other file of the block refers to it by scoped names
package skf_pkg;

	localparam int DATA_W  = 32;
	localparam int QUO_W   = 32;
	localparam int CLAMP_W = 35;
	localparam int SUM_W   = CLAMP_W + 2;
	localparam int STEP_W  = 5;
	localparam int PADDR_W = 4;

	localparam logic [DATA_W-1:0]  S_MAX    = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0]  S_MIN    = 32'h8000_0000;
	localparam logic [DATA_W-1:0]  U_MAX    = 32'hFFFF_FFFF;
	localparam logic [CLAMP_W-1:0] C_LIMIT  = 35'h4_0000_0000;
	localparam logic [DATA_W-1:0]  R_RESET  = 32'h0010_0000;
	localparam logic [DATA_W-1:0]  Q_RESET  = 32'h0004_0000;
	localparam logic [DATA_W-1:0]  H_RESET  = 32'h0001_0000;

	typedef logic [STEP_W-1:0] step_t;

	// configuration register indexes (byte address / 4)
	typedef enum logic [1:0] {
		REG_MEAS_NOISE = 2'd0,
		REG_PROC_NOISE = 2'd1,
		REG_MEAS_GAIN  = 2'd2
	} reg_idx_t;

	// multiplier operand a
	typedef enum logic [2:0] {
		MA_HABS,
		MA_P,
		MA_HH_LO,
		MA_HH_HI,
		MA_KMAG
	} mul_a_t;

	// multiplier operand b
	typedef enum logic [2:0] {
		MB_HABS,
		MB_REFF,
		MB_P,
		MB_XABS,
		MB_INN_LO,
		MB_INN_HI
	} mul_b_t;

	// datapath register transfers
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LD_IN,
		OP_LD_HH,
		OP_LD_NUMK,
		OP_LD_NUMP,
		OP_LD_ACC,
		OP_ADD_ACC_HI,
		OP_LD_HX,
		OP_LD_DEN,
		OP_DIV_GO,
		OP_LD_INN,
		OP_LD_INNM,
		OP_LD_K,
		OP_LD_P,
		OP_LD_C,
		OP_EMIT
	} op_t;

	// sequencing: hold steps jump to target until their condition is met
	typedef enum logic [2:0] {
		J_NEXT,
		J_HOLD_IN,
		J_HOLD_DIV,
		J_HOLD_OUT,
		J_GOTO
	} jmp_t;

	typedef struct packed {
		op_t    op;
		mul_a_t ma;
		mul_b_t mb;
		jmp_t   jmp;
		step_t  target;
	} ctrl_t;

	typedef struct packed {
		logic [DATA_W-1:0] r;
		logic [DATA_W-1:0] q;
		logic [DATA_W-1:0] h;
	} cfg_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
	} dp_stat_t;

	// microcode rom: one control word per step
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		c = '{op: OP_NOP, ma: MA_HABS, mb: MB_HABS, jmp: J_NEXT, target: '0};
		unique case (s)
			5'd0: begin
				c.op = OP_LD_IN;
				c.jmp = J_HOLD_IN;
				c.target = 5'd0;
			end
			5'd1: begin
				c.ma = MA_HABS;
				c.mb = MB_HABS;
			end
			5'd2: begin
				c.op = OP_LD_HH;
				c.ma = MA_P;
				c.mb = MB_HABS;
			end
			5'd3: begin
				c.op = OP_LD_NUMK;
				c.ma = MA_P;
				c.mb = MB_REFF;
			end
			5'd4: begin
				c.op = OP_LD_NUMP;
				c.ma = MA_HH_LO;
				c.mb = MB_P;
			end
			5'd5: begin
				c.op = OP_LD_ACC;
				c.ma = MA_HH_HI;
				c.mb = MB_P;
			end
			5'd6: begin
				c.op = OP_ADD_ACC_HI;
				c.ma = MA_HABS;
				c.mb = MB_XABS;
			end
			5'd7:  c.op = OP_LD_HX;
			5'd8:  c.op = OP_LD_DEN;
			5'd9:  c.op = OP_DIV_GO;
			5'd10: c.op = OP_LD_INN;
			5'd11: c.op = OP_LD_INNM;
			5'd12: begin
				c.jmp = J_HOLD_DIV;
				c.target = 5'd12;
			end
			5'd13: c.op = OP_LD_K;
			5'd14: begin
				c.op = OP_LD_P;
				c.ma = MA_KMAG;
				c.mb = MB_INN_LO;
			end
			5'd15: begin
				c.op = OP_LD_ACC;
				c.ma = MA_KMAG;
				c.mb = MB_INN_HI;
			end
			5'd16: c.op = OP_ADD_ACC_HI;
			5'd17: c.op = OP_LD_C;
			5'd18: begin
				c.jmp = J_HOLD_OUT;
				c.target = 5'd18;
			end
			5'd19: begin
				c.op = OP_EMIT;
				c.jmp = J_GOTO;
				c.target = 5'd0;
			end
			default: begin
				c.jmp = J_GOTO;
				c.target = 5'd0;
			end
		endcase
		return c;
	endfunction

endpackage

FILE: hdl/skf_ifs.sv
// skf_ifs: valid/ready stream interfaces of the scalar kalman filter
// sensor samples in, filtered results out
// depends on skf_pkg for the data width
interface skf_sensor_if;
	logic                              valid;
	logic                              ready;
	logic signed [skf_pkg::DATA_W-1:0] sample;
	logic                              preload;

	modport source(output valid, output sample, output preload, input ready);
	modport sink(input valid, input sample, input preload, output ready);
endinterface

interface skf_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [skf_pkg::DATA_W-1:0] estimate;
	logic signed [skf_pkg::DATA_W-1:0] gain;

	modport source(output valid, output estimate, output gain, input ready);
	modport sink(input valid, input estimate, input gain, output ready);
endinterface

FILE: hdl/scalar_kalman_filter_unit.sv
// scalar_kalman_filter_unit: one-dimensional fixed-point kalman filter
//
// sensor (sink): one transfer per sample; sample is signed with FRAC_BITS
// fraction bits, preload seeds the estimate with the sample first.
// filtered (source): one transfer per sample carrying the new estimate and
// the gain used, both signed, same format.
// apb port: measurement noise R at 0x0, process noise Q at 0x4, measurement
// gain H at 0x8; pready is tied high, writes land on the access cycle.
// the gain and the covariance update come from a restoring division (two
// lanes, one quotient bit per cycle), with the rest of the program spent
// in single-multiplier steps of the microcode program.
// sensor is ready only while the sequencer waits at its first step; the
// result sits in an output register, so the next sample is taken and
// worked on while a result is stalled, and the program waits before its
// last step until that register is free.
// reset clears estimate and covariance to zero and loads R=16.0, Q=4.0,
// H=1.0; no result is pending after reset.
// depends on skf_pkg, skf_ifs, skf_sequencer, skf_datapath, skf_divider
module scalar_kalman_filter_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	skf_sensor_if.sink                    sensor,
	skf_result_if.source                  filtered,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [skf_pkg::PADDR_W-1:0]   paddr,
	input  logic [skf_pkg::DATA_W-1:0]    pwdata,
	output logic [skf_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	skf_pkg::cfg_t     cfg_q;
	skf_pkg::ctrl_t    ctrl;
	skf_pkg::dp_stat_t stat;
	skf_pkg::reg_idx_t reg_idx;
	logic              cfg_we;

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite;
	assign reg_idx = skf_pkg::reg_idx_t'(paddr[3:2]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.r <= skf_pkg::R_RESET;
			cfg_q.q <= skf_pkg::Q_RESET;
			cfg_q.h <= skf_pkg::H_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx)
				skf_pkg::REG_MEAS_NOISE: cfg_q.r <= pwdata;
				skf_pkg::REG_PROC_NOISE: cfg_q.q <= pwdata;
				skf_pkg::REG_MEAS_GAIN:  cfg_q.h <= pwdata;
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			skf_pkg::REG_MEAS_NOISE: prdata = cfg_q.r;
			skf_pkg::REG_PROC_NOISE: prdata = cfg_q.q;
			skf_pkg::REG_MEAS_GAIN:  prdata = cfg_q.h;
			default:                 prdata = '0;
		endcase
	end

	// program sequencer
	skf_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sensor.valid),
		.stat     (stat),
		.in_ready (sensor.ready),
		.ctrl     (ctrl)
	);

	// arithmetic and state
	skf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg       (cfg_q),
		.sample    (sensor.sample),
		.preload   (sensor.preload),
		.res_ready (filtered.ready),
		.res_valid (filtered.valid),
		.estimate  (filtered.estimate),
		.gain      (filtered.gain),
		.stat      (stat)
	);

endmodule

FILE: hdl/skf_divider.sv
// skf_divider: restoring divider, one quotient bit per cycle, 32-bit quotient
// flags overflow when the quotient would need more than 32 bits
// depends on skf_pkg
module skf_divider #(
	parameter int NUM_W = 96,
	parameter int DEN_W = 95
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           num,
	input  logic [DEN_W-1:0]           den,
	output logic                       busy,
	output logic [skf_pkg::QUO_W-1:0]  quo,
	output logic                       ovf
);

	localparam int QW    = skf_pkg::QUO_W;
	localparam int CNT_W = $clog2(QW + 1);

	logic [DEN_W-1:0] rem_q;
	logic [QW-1:0]    quo_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [DEN_W-1:0] rem_init;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// upper dividend bits start the remainder; low bits shift in one per cycle
	assign rem_init = DEN_W'(num[NUM_W-1:QW]);
	assign trial    = {rem_q, quo_q[QW-1]};
	assign ge       = trial >= {1'b0, den};
	assign diff     = trial - {1'b0, den};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			quo_q <= num[QW-1:0];
			ovf_q <= rem_init >= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign ovf  = ovf_q;

endmodule

FILE: hdl/skf_sequencer.sv
// skf_sequencer: step counter over the microcode rom with hold and goto jumps
// hands the current control word to the datapath, gated while a step holds
// depends on skf_pkg
module skf_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  skf_pkg::dp_stat_t   stat,
	output logic                in_ready,
	output skf_pkg::ctrl_t      ctrl
);

	skf_pkg::step_t step_q;
	skf_pkg::step_t step_nxt;
	skf_pkg::ctrl_t cw;
	logic           adv;

	assign cw = skf_pkg::ucode(step_q);

	// next step selection
	always_comb begin
		adv      = 1'b1;
		step_nxt = step_q + 1'b1;
		unique case (cw.jmp)
			skf_pkg::J_NEXT: begin
				adv      = 1'b1;
				step_nxt = step_q + 1'b1;
			end
			skf_pkg::J_HOLD_IN: begin
				adv      = in_valid;
				step_nxt = in_valid ? step_q + 1'b1 : cw.target;
			end
			skf_pkg::J_HOLD_DIV: begin
				adv      = !stat.div_busy;
				step_nxt = stat.div_busy ? cw.target : step_q + 1'b1;
			end
			skf_pkg::J_HOLD_OUT: begin
				adv      = stat.out_free;
				step_nxt = stat.out_free ? step_q + 1'b1 : cw.target;
			end
			skf_pkg::J_GOTO: begin
				adv      = 1'b1;
				step_nxt = cw.target;
			end
			default: begin
				adv      = 1'b1;
				step_nxt = cw.target;
			end
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_nxt;
		end
	end

	// a holding step performs no transfer
	always_comb begin
		ctrl = cw;
		if (!adv) begin
			ctrl.op = skf_pkg::OP_NOP;
		end
	end

	assign in_ready = (cw.jmp == skf_pkg::J_HOLD_IN);

endmodule

FILE: hdl/skf_datapath.sv
// skf_datapath: shared 32x32 multiplier, accumulator, working registers,
// two divider lanes on a common divisor, filter state and output register
// depends on skf_pkg and skf_divider
module skf_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  skf_pkg::ctrl_t                    ctrl,
	input  skf_pkg::cfg_t                     cfg,
	input  logic signed [skf_pkg::DATA_W-1:0] sample,
	input  logic                              preload,
	input  logic                              res_ready,
	output logic                              res_valid,
	output logic signed [skf_pkg::DATA_W-1:0] estimate,
	output logic signed [skf_pkg::DATA_W-1:0] gain,
	output skf_pkg::dp_stat_t                 stat
);

	localparam int DW     = skf_pkg::DATA_W;
	localparam int QW     = skf_pkg::QUO_W;
	localparam int CW     = skf_pkg::CLAMP_W;
	localparam int SW     = skf_pkg::SUM_W;
	localparam int SH2    = 2 * FRAC_BITS;
	localparam int NUM_W  = 2 * DW + SH2;
	localparam int DEN_W  = (((DW + SH2) > (3 * DW - 2)) ? (DW + SH2) : (3 * DW - 2)) + 1;
	localparam int HXM_W  = 2 * DW - FRAC_BITS;
	localparam int HX_W   = HXM_W + 1;
	localparam int INN_W  = HX_W + 1;
	localparam int INH_W  = INN_W - DW;
	localparam int ACC_W  = ((DW + INN_W) > (3 * DW)) ? (DW + INN_W) : (3 * DW);

	// filter state
	logic signed [DW-1:0] x_q;
	logic [DW-1:0]        p_q;
	logic                 res_valid_q;

	// working registers
	logic signed [DW-1:0]    u_q;
	logic [2*DW-1:0]         hh_q;
	logic [NUM_W-1:0]        num_k_q;
	logic [NUM_W-1:0]        num_p_q;
	logic [ACC_W-1:0]        acc_q;
	logic [DEN_W-1:0]        den_q;
	logic signed [HX_W-1:0]  hx_q;
	logic signed [INN_W-1:0] inn_q;
	logic [INN_W-1:0]        innm_q;
	logic                    inn_neg_q;
	logic [DW-1:0]           kmag_q;
	logic [CW-1:0]           c_q;
	logic [2*DW-1:0]         prod_s1;
	logic signed [DW-1:0]    est_q;
	logic signed [DW-1:0]    gain_q;

	// combinational terms
	logic                 h_neg;
	logic [DW-1:0]        habs;
	logic [DW-1:0]        r_eff;
	logic [DW-1:0]        xabs;
	logic [DW-1:0]        mul_a;
	logic [DW-1:0]        mul_b;
	logic [HXM_W-1:0]     hxm;
	logic signed [HX_W-1:0] hx_pos;
	logic                 div_go;
	logic                 busy_k, busy_p;
	logic [QW-1:0]        quo_k, quo_p;
	logic                 ovf_k, ovf_p;
	logic                 k_sat;
	logic [DW-1:0]        kmag_nxt;
	logic [DW:0]          p_sum;
	logic [DW-1:0]        p_nxt;
	logic [ACC_W-1:0]     c_full;
	logic [CW-1:0]        c_nxt;
	logic signed [SW-1:0] x_ext;
	logic signed [SW-1:0] c_ext;
	logic signed [SW-1:0] x_sum;
	logic [SW-DW:0]       x_top;
	logic signed [DW-1:0] x_nxt;
	logic [DW-1:0]        gain_nxt;
	logic                 emit;

	// operand conditioning
	assign h_neg = cfg.h[DW-1];
	assign habs  = h_neg ? (~cfg.h + 1'b1) : cfg.h;
	assign r_eff = (cfg.r == '0) ? DW'(1) : cfg.r;
	assign xabs  = x_q[DW-1] ? DW'(-x_q) : DW'(x_q);

	// multiplier operand select
	always_comb begin
		unique case (ctrl.ma)
			skf_pkg::MA_HABS:  mul_a = habs;
			skf_pkg::MA_P:     mul_a = p_q;
			skf_pkg::MA_HH_LO: mul_a = hh_q[DW-1:0];
			skf_pkg::MA_HH_HI: mul_a = hh_q[2*DW-1:DW];
			skf_pkg::MA_KMAG:  mul_a = kmag_q;
			default:           mul_a = '0;
		endcase
	end

	always_comb begin
		unique case (ctrl.mb)
			skf_pkg::MB_HABS:   mul_b = habs;
			skf_pkg::MB_REFF:   mul_b = r_eff;
			skf_pkg::MB_P:      mul_b = p_q;
			skf_pkg::MB_XABS:   mul_b = xabs;
			skf_pkg::MB_INN_LO: mul_b = innm_q[DW-1:0];
			skf_pkg::MB_INN_HI: mul_b = DW'(innm_q[INN_W-1:DW]);
			default:            mul_b = '0;
		endcase
	end

	// registered product
	always_ff @(posedge clk) begin
		prod_s1 <= {{DW{1'b0}}, mul_a} * {{DW{1'b0}}, mul_b};
	end

	// two divider lanes share the denominator
	assign div_go = (ctrl.op == skf_pkg::OP_DIV_GO);

	skf_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_k (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (num_k_q),
		.den    (den_q),
		.busy   (busy_k),
		.quo    (quo_k),
		.ovf    (ovf_k)
	);

	skf_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_p (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (num_p_q),
		.den    (den_q),
		.busy   (busy_p),
		.quo    (quo_p),
		.ovf    (ovf_p)
	);

	// h*x scaled back, signed
	assign hxm    = prod_s1[2*DW-1:FRAC_BITS];
	assign hx_pos = $signed({1'b0, hxm});

	// gain magnitude with saturation
	assign k_sat    = ovf_k | quo_k[QW-1];
	assign kmag_nxt = k_sat ? (h_neg ? skf_pkg::S_MIN : skf_pkg::S_MAX) : quo_k;
	assign gain_nxt = h_neg ? (~kmag_q + 1'b1) : kmag_q;

	// covariance update, saturating
	assign p_sum = {1'b0, quo_p} + {1'b0, cfg.q};
	assign p_nxt = (ovf_p | p_sum[DW]) ? skf_pkg::U_MAX : p_sum[DW-1:0];

	// correction term, clamped
	assign c_full = acc_q >> FRAC_BITS;
	assign c_nxt  = (c_full > ACC_W'(skf_pkg::C_LIMIT)) ? skf_pkg::C_LIMIT : c_full[CW-1:0];

	// estimate update, saturated to 32 bits
	assign x_ext = {{(SW-DW){x_q[DW-1]}}, x_q};
	assign c_ext = $signed({{(SW-CW){1'b0}}, c_q});
	assign x_sum = (h_neg ^ inn_neg_q) ? (x_ext - c_ext) : (x_ext + c_ext);
	assign x_top = x_sum[SW-1:DW-1];
	always_comb begin
		if ((&x_top) || !(|x_top)) begin
			x_nxt = x_sum[DW-1:0];
		end else begin
			x_nxt = x_sum[SW-1] ? skf_pkg::S_MIN : skf_pkg::S_MAX;
		end
	end

	assign emit = (ctrl.op == skf_pkg::OP_EMIT);

	// filter state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			p_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == skf_pkg::OP_LD_IN && preload) begin
				x_q <= sample;
			end
			if (ctrl.op == skf_pkg::OP_LD_P) begin
				p_q <= p_nxt;
			end
			if (emit) begin
				x_q         <= x_nxt;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// working register transfers
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			skf_pkg::OP_LD_IN:      u_q     <= sample;
			skf_pkg::OP_LD_HH:      hh_q    <= prod_s1;
			skf_pkg::OP_LD_NUMK:    num_k_q <= NUM_W'(prod_s1) << SH2;
			skf_pkg::OP_LD_NUMP:    num_p_q <= NUM_W'(prod_s1) << SH2;
			skf_pkg::OP_LD_ACC:     acc_q   <= ACC_W'(prod_s1);
			skf_pkg::OP_ADD_ACC_HI: acc_q   <= acc_q + (ACC_W'(prod_s1) << DW);
			skf_pkg::OP_LD_HX:      hx_q    <= (h_neg ^ x_q[DW-1]) ? -hx_pos : hx_pos;
			skf_pkg::OP_LD_DEN:     den_q   <= DEN_W'(acc_q) + (DEN_W'(r_eff) << SH2);
			skf_pkg::OP_LD_INN: begin
				inn_q <= {{(INN_W-DW){u_q[DW-1]}}, u_q} - {hx_q[HX_W-1], hx_q};
			end
			skf_pkg::OP_LD_INNM: begin
				inn_neg_q <= inn_q[INN_W-1];
				innm_q    <= inn_q[INN_W-1] ? INN_W'(-inn_q) : INN_W'(inn_q);
			end
			skf_pkg::OP_LD_K:       kmag_q  <= kmag_nxt;
			skf_pkg::OP_LD_C:       c_q     <= c_nxt;
			skf_pkg::OP_EMIT: begin
				est_q  <= x_nxt;
				gain_q <= gain_nxt;
			end
			default: ;
		endcase
	end

	assign res_valid     = res_valid_q;
	assign estimate      = est_q;
	assign gain          = gain_q;
	assign stat.div_busy = busy_k | busy_p;
	assign stat.out_free = !res_valid_q || res_ready;

endmodule

FILE: tb/sv/skf_checker.sv
// skf_checker: watches the sensor, result and register ports of the kalman filter unit
// keeps its own fixed-point filter state, predicts each result and compares it by field
// depends on skf_pkg and skf_ifs
`timescale 1ns / 1ps

module skf_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	skf_sensor_if                       sensor,
	skf_result_if                       filtered,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [skf_pkg::PADDR_W-1:0] paddr,
	input  logic [skf_pkg::DATA_W-1:0]  pwdata,
	input  logic [skf_pkg::DATA_W-1:0]  prdata,
	input  logic                        pready,
	output int                          fail_count,
	output int                          pending
);

	localparam int                 DATA_W       = skf_pkg::DATA_W;
	localparam int                 REPORT_LIMIT = 10;
	localparam logic signed [63:0] EST_MAX      = 64'sd2147483647;
	localparam logic signed [63:0] EST_MIN      = -64'sd2147483648;

	typedef struct packed {
		logic signed [DATA_W-1:0] estimate;
		logic signed [DATA_W-1:0] gain;
	} filter_out_t;

	// filter state and register copies
	logic signed [63:0]       x_est;
	logic [DATA_W-1:0]        p_cov;
	logic [DATA_W-1:0]        cfg_r;
	logic [DATA_W-1:0]        cfg_q;
	logic signed [DATA_W-1:0] cfg_h;

	filter_out_t estimate_gain_q[$];
	filter_out_t want;
	int          mismatches = 0;

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_readback(input string name, input logic [DATA_W-1:0] val);
		if (prdata !== val)
			note_failure($sformatf("read of %s: expected %h, got %h", name, val, prdata));
	endtask

	// one filter step: gain, estimate update, covariance update
	function automatic filter_out_t kalman_update(input logic signed [DATA_W-1:0] u,
			input logic load);
		logic signed [63:0] h, uw, hx, inn;
		logic [63:0]        habs, xabs, innm, kmag, hxm, r_eff, kval;
		logic [127:0]       den, kq, corr, pq, pnext;
		logic               kneg;
		filter_out_t        res;
		h = {{32{cfg_h[DATA_W-1]}}, cfg_h};
		uw = {{32{u[DATA_W-1]}}, u};
		kneg = cfg_h[DATA_W-1];
		habs = kneg ? -h : h;
		// zero noise is taken as one lsb
		r_eff = (cfg_r == '0) ? 64'd1 : {32'd0, cfg_r};
		if (load)
			x_est = uw;

		// gain magnitude, saturated to the signed range
		den = {64'd0, habs} * {64'd0, habs} * {96'd0, p_cov}
			+ ({64'd0, r_eff} << (2 * FRAC_BITS));
		kq = (({96'd0, p_cov} * {64'd0, habs}) << (2 * FRAC_BITS)) / den;
		kmag = (kq > 128'h7FFF_FFFF) ? 64'h7FFF_FFFF : kq[63:0];
		if (kneg && kq >= 128'h8000_0000)
			kmag = 64'h8000_0000;
		kval = kneg ? 64'd0 - kmag : kmag;

		// innovation against the mapped estimate
		xabs = x_est[63] ? -x_est : x_est;
		hxm = (habs * xabs) >> FRAC_BITS;
		hx = (kneg != x_est[63]) ? -$signed(hxm) : $signed(hxm);
		inn = uw - hx;
		innm = inn[63] ? -inn : inn;

		// correction, clamped, then the estimate saturated
		corr = ({64'd0, kmag} * {64'd0, innm}) >> FRAC_BITS;
		if (corr > 128'(skf_pkg::C_LIMIT))
			corr = 128'(skf_pkg::C_LIMIT);
		if (kneg != inn[63])
			x_est = x_est - $signed(corr[63:0]);
		else
			x_est = x_est + $signed(corr[63:0]);
		if (x_est > EST_MAX)
			x_est = EST_MAX;
		else if (x_est < EST_MIN)
			x_est = EST_MIN;

		// covariance shrink plus process noise, saturated unsigned
		pq = (({96'd0, p_cov} * {64'd0, r_eff}) << (2 * FRAC_BITS)) / den;
		pnext = pq + {96'd0, cfg_q};
		p_cov = (pnext > {96'd0, skf_pkg::U_MAX}) ? skf_pkg::U_MAX : pnext[DATA_W-1:0];

		res.estimate = x_est[DATA_W-1:0];
		res.gain = kval[DATA_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_est = '0;
			p_cov = '0;
			cfg_r = skf_pkg::R_RESET;
			cfg_q = skf_pkg::Q_RESET;
			cfg_h = skf_pkg::H_RESET;
			estimate_gain_q.delete();
			pending <= 0;
			fail_count <= mismatches;
		end else begin
			// register port access cycle
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[skf_pkg::PADDR_W-1:2])
						skf_pkg::REG_MEAS_NOISE: cfg_r = pwdata;
						skf_pkg::REG_PROC_NOISE: cfg_q = pwdata;
						skf_pkg::REG_MEAS_GAIN:  cfg_h = pwdata;
						default: ;
					endcase
				end else begin
					case (paddr[skf_pkg::PADDR_W-1:2])
						skf_pkg::REG_MEAS_NOISE: check_readback("measurement noise", cfg_r);
						skf_pkg::REG_PROC_NOISE: check_readback("process noise", cfg_q);
						skf_pkg::REG_MEAS_GAIN:  check_readback("measurement gain", cfg_h);
						default: ;
					endcase
				end
			end

			// sample transfer
			if (sensor.valid && sensor.ready)
				estimate_gain_q.push_back(kalman_update(sensor.sample, sensor.preload));

			// result transfer
			if (filtered.valid && filtered.ready) begin
				if (estimate_gain_q.size() == 0) begin
					note_failure($sformatf("result with none pending: estimate %h gain %h",
						filtered.estimate, filtered.gain));
				end else begin
					want = estimate_gain_q.pop_front();
					if (filtered.estimate !== want.estimate)
						note_failure($sformatf("estimate: expected %h, got %h",
							want.estimate, filtered.estimate));
					if (filtered.gain !== want.gain)
						note_failure($sformatf("gain: expected %h, got %h",
							want.gain, filtered.gain));
				end
			end

			pending <= estimate_gain_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: clock, reset, sample stimulus, register setup and verdict for the kalman filter unit
// directed corner samples first, then random phases with random noise, gain and flow control
// depends on skf_pkg, skf_ifs, scalar_kalman_filter_unit and skf_checker
`timescale 1ns / 1ps

module tb_top;

	localparam int                          FRAC_BITS       = 16;
	localparam int                          RANDOM_PHASES   = 6;
	localparam int                          ITEMS_PER_PHASE = 75;
	localparam int                          DRAIN_CYCLES    = 120;
	localparam int                          CYCLE_LIMIT     = 400000;
	localparam logic [skf_pkg::PADDR_W-1:0] ADDR_UNUSED     = 4'hC;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [skf_pkg::PADDR_W-1:0] paddr;
	logic [skf_pkg::DATA_W-1:0]  pwdata;
	logic [skf_pkg::DATA_W-1:0]  prdata;
	logic                        pready;
	int                          fail_count;
	int                          pending;
	int                          cycle_count = 0;
	idle_mode_t                  idle_mode = IDLE_NONE;

	skf_sensor_if sensor_ch();
	skf_result_if result_ch();

	scalar_kalman_filter_unit #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sensor(sensor_ch),
		.filtered(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	skf_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.sensor(sensor_ch),
		.filtered(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[scalar_kalman_filter_unit] ERROR");
			$finish;
		end
	end

	// result side stalls
	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECEIVER: result_ch.ready <= ($urandom_range(99) >= 56);
			IDLE_BOTH:     result_ch.ready <= ($urandom_range(99) >= 30);
			default:       result_ch.ready <= 1'b1;
		endcase
	end

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(99) < 56;
			IDLE_BOTH:   return $urandom_range(99) < 30;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic logic [skf_pkg::PADDR_W-1:0] reg_addr(input skf_pkg::reg_idx_t idx);
		return {idx, 2'b00};
	endfunction

	// one register transfer: setup, access, then idle
	task automatic apb_transfer(input logic wr, input logic [skf_pkg::PADDR_W-1:0] addr,
			input logic [skf_pkg::DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// one sample transfer, with random idle cycles ahead of it
	task automatic send_sample(input logic signed [skf_pkg::DATA_W-1:0] smp, input logic pl);
		while (sender_idles()) begin
			sensor_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sensor_ch.valid <= 1'b1;
		sensor_ch.sample <= smp;
		sensor_ch.preload <= pl;
		@(posedge clk);
		while (!sensor_ch.ready)
			@(posedge clk);
	endtask

	// hold off until every expected result has come out
	task automatic wait_filter_drained();
		sensor_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// new noise and gain settings, written and read back while the unit is idle
	task automatic load_filter_config(input logic [skf_pkg::DATA_W-1:0] r,
			input logic [skf_pkg::DATA_W-1:0] q, input logic [skf_pkg::DATA_W-1:0] h,
			input idle_mode_t mode);
		wait_filter_drained();
		idle_mode <= mode;
		apb_transfer(1'b1, reg_addr(skf_pkg::REG_MEAS_NOISE), r);
		apb_transfer(1'b1, reg_addr(skf_pkg::REG_PROC_NOISE), q);
		apb_transfer(1'b1, reg_addr(skf_pkg::REG_MEAS_GAIN), h);
		apb_transfer(1'b0, reg_addr(skf_pkg::REG_MEAS_NOISE), '0);
		apb_transfer(1'b0, reg_addr(skf_pkg::REG_PROC_NOISE), '0);
		apb_transfer(1'b0, reg_addr(skf_pkg::REG_MEAS_GAIN), '0);
	endtask

	function automatic logic [skf_pkg::DATA_W-1:0] pick_noise();
		case ($urandom_range(9))
			0:       return '0;
			1:       return 32'd1;
			2:       return skf_pkg::U_MAX;
			3, 4:    return $urandom;
			default: return $urandom_range(32'h0040_0000);
		endcase
	endfunction

	function automatic logic [skf_pkg::DATA_W-1:0] pick_map();
		logic [skf_pkg::DATA_W-1:0] v;
		case ($urandom_range(9))
			0:       v = '0;
			1:       v = 32'd1;
			2:       v = skf_pkg::S_MIN;
			3:       v = skf_pkg::S_MAX;
			4:       v = skf_pkg::U_MAX;
			5:       v = $urandom;
			default: begin
				// near unity, either sign
				v = $urandom_range(32'h0002_0000);
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic idle_mode_t mode_for_phase(input int ph);
		case (ph % 4)
			0:       return IDLE_BOTH;
			1:       return IDLE_SENDER;
			2:       return IDLE_RECEIVER;
			default: return IDLE_NONE;
		endcase
	endfunction

	initial begin
		logic signed [skf_pkg::DATA_W-1:0] level;
		logic signed [skf_pkg::DATA_W-1:0] smp;
		logic                              pl;
		int                                roll;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sensor_ch.valid = 1'b0;
		sensor_ch.sample = '0;
		sensor_ch.preload = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings, sample extremes and preload
		load_filter_config(skf_pkg::R_RESET, skf_pkg::Q_RESET, skf_pkg::H_RESET, IDLE_NONE);
		send_sample('0, 1'b1);
		send_sample(skf_pkg::S_MAX, 1'b0);
		send_sample(skf_pkg::S_MIN, 1'b0);
		send_sample(skf_pkg::S_MIN, 1'b1);
		send_sample(skf_pkg::S_MAX, 1'b1);
		send_sample('0, 1'b0);
		send_sample(32'h0001_0000, 1'b0);
		send_sample(32'hFFFF_0000, 1'b0);

		// zero noise, tiny map and maximum process noise: gain near its limit
		load_filter_config('0, skf_pkg::U_MAX, 32'd1, IDLE_NONE);
		send_sample(skf_pkg::S_MAX, 1'b1);
		send_sample(skf_pkg::S_MIN, 1'b0);
		send_sample('0, 1'b0);
		send_sample(32'h0000_3039, 1'b0);

		// zero map: gain stays zero while the covariance grows
		load_filter_config(32'h0001_0000, 32'h0001_0000, '0, IDLE_NONE);
		send_sample(32'h0010_0000, 1'b1);
		send_sample(skf_pkg::S_MIN, 1'b0);
		send_sample(32'h0000_7FFF, 1'b0);

		// most negative map, largest noise; a write to the unused address goes nowhere
		load_filter_config(skf_pkg::U_MAX, '0, skf_pkg::S_MIN, IDLE_NONE);
		apb_transfer(1'b1, ADDR_UNUSED, $urandom);
		send_sample(skf_pkg::S_MAX, 1'b0);
		send_sample(skf_pkg::S_MIN, 1'b1);
		send_sample('0, 1'b0);

		// map of minus one lsb
		load_filter_config(32'd1, skf_pkg::U_MAX, skf_pkg::U_MAX, IDLE_NONE);
		send_sample(skf_pkg::S_MIN, 1'b1);
		send_sample(skf_pkg::S_MAX, 1'b0);
		send_sample(skf_pkg::S_MAX, 1'b0);

		// largest positive map
		load_filter_config(skf_pkg::U_MAX, '0, skf_pkg::S_MAX, IDLE_NONE);
		send_sample(32'd1, 1'b0);
		send_sample(skf_pkg::S_MIN, 1'b0);

		// random phases: a noisy level with outliers and occasional reseeding
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			load_filter_config(pick_noise(), pick_noise(), pick_map(), mode_for_phase(ph));
			level = $signed($urandom) >>> 3;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				roll = $urandom_range(99);
				if (roll < 60)
					smp = level + $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
				else if (roll < 85)
					smp = $urandom;
				else if (roll < 90)
					smp = skf_pkg::S_MAX;
				else if (roll < 95)
					smp = skf_pkg::S_MIN;
				else
					smp = '0;
				pl = (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 8);
				send_sample(smp, pl);
			end
		end

		wait_filter_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[scalar_kalman_filter_unit] OK");
		else
			$display("[scalar_kalman_filter_unit] ERROR");
		$finish;
	end

endmodule
